// ----- hdl/kta_pkg.sv -----
// shared types and constants of the keystroke timing anomaly detector
`timescale 1ns / 1ps

package kta_pkg;

   localparam int TIME_W     = 32;
   localparam int IV_W       = 16;
   localparam int SQ1_W      = 32;
   localparam int MEAN_W     = 10;
   localparam int VLIM_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int FIFO_DEPTH = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_LIMIT  = CSR_IDX_W'(1);

   localparam logic [MEAN_W-1:0] MEAN_RESET = MEAN_W'(10);
   localparam logic [VLIM_W-1:0] VLIM_RESET = VLIM_W'(2);
   localparam logic [IV_W-1:0]   IV_MAX     = '1;

   // one event on its way through the pipeline
   typedef struct packed {
      logic            valid;
      logic            key;
      logic            upd;
      logic            full;
      logic [IV_W-1:0] interval;
   } stage_type;

   typedef struct packed {
      logic            block_key;
      logic [IV_W-1:0] interval_ms;
      logic            window_full;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } test_result_type;

endpackage

// ----- hdl/keystroke_timing_anomaly_detector.sv -----
// top level of the keystroke timing anomaly detector
`timescale 1ns / 1ps

// Flags injected typing from key-down timing. Each key-down event (req_tuser
// high) forms the interval since the previous key-down, saturated to 16 bits;
// the last WINDOW intervals sit in a chain of cells with a running sum and sum
// of squares. With the window full the key is flagged (rsp_tuser[0]) when the
// mean is below mean_limit_ms and the population variance below
// variance_limit, and a flag empties the window. Other events change nothing
// and return interval 0 with the current window-full status. Every transfer
// in gives exactly one transfer out, in order. After each transfer the intake
// pauses, set by the window update loop: a clear caused by the flat-window
// test of one update must reach the next update; events still overlap in the
// pipeline. A result passes s1, s2, s3, the test register and the queue.
// Up to 4 results queue at the output, and input stalls when they are all
// outstanding. Configuration writes are always taken (csr_ready tied high).

module keystroke_timing_anomaly_detector #(
   parameter int WINDOW = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   // event input
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kta_pkg::TIME_W-1:0]       req_tdata,  // [31:0] time_ms
   input  logic                             req_tuser,  // [0] key_down
   // result output
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kta_pkg::IV_W-1:0]         rsp_tdata,  // [15:0] interval_ms
   output logic [1:0]                       rsp_tuser,  // [0] block_key, [1] window_full
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kta_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kta_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kta_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = IV_W + $clog2(WINDOW);
   localparam int SQ_W   = SQ1_W + $clog2(WINDOW);
   localparam int PEND_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW);

   // configuration registers
   logic [MEAN_W-1:0] mean_limit_ff;
   logic [VLIM_W-1:0] var_limit_ff;

   // input side control
   logic              req_accept;
   logic              gap_ff;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              rsp_pop;
   logic [TIME_W-1:0] prev_time_ff;
   logic              have_prev_ff;
   logic [TIME_W-1:0] delta;
   logic [IV_W-1:0]   sat_iv;

   // pipeline stages
   stage_type         s1_in, s1_ff;
   stage_type         s2_ff;
   logic [SQ1_W-1:0]  s2_sq_ff;
   stage_type         s3_in, s3_ff;

   // window state
   logic [CNT_W-1:0]  fill_ff, fill_in, fill_eff;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_eff;
   logic [SQ_W-1:0]   sq_ff, sq_in, sq_eff;
   logic              full_eff;
   logic              shift_en;
   logic              flag_now;
   logic [IV_W-1:0]   cell_iv [WINDOW];
   logic [SQ1_W-1:0]  cell_sq [WINDOW];

   test_result_type   test_result;
   rsp_type           fifo_out;

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_limit_ff <= MEAN_RESET;
         var_limit_ff  <= VLIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MEAN_LIMIT: mean_limit_ff <= csr_wdata[MEAN_W-1:0];
            CSR_VAR_LIMIT:  var_limit_ff  <= csr_wdata[VLIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- intake
   // a gap after each transfer, and never more outstanding results than the
   // output queue holds
   assign req_tready = ~gap_ff & (pend_ff < PEND_W'(FIFO_DEPTH));
   assign req_accept = req_tvalid & req_tready;
   assign rsp_pop    = rsp_tvalid & rsp_tready;
   assign pend_in    = pend_ff + PEND_W'(req_accept) - PEND_W'(rsp_pop);

   // interval modulo 2^32, saturated to 16 bits
   assign delta  = req_tdata - prev_time_ff;
   assign sat_iv = (|delta[TIME_W-1:IV_W]) ? IV_MAX : delta[IV_W-1:0];

   always_comb begin
      s1_in.valid    = req_accept;
      s1_in.key      = req_tuser;
      s1_in.upd      = req_tuser & have_prev_ff;
      s1_in.full     = 1'b0;
      s1_in.interval = (req_tuser & have_prev_ff) ? sat_iv : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= 1'b0;
         pend_ff      <= '0;
         have_prev_ff <= 1'b0;
         prev_time_ff <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
      end else begin
         gap_ff  <= req_accept;
         pend_ff <= pend_in;
         if (req_accept & req_tuser) begin
            prev_time_ff <= req_tdata;
            have_prev_ff <= 1'b1;
         end
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
      end
      // square of the new interval, one stage ahead of the window update
      s2_sq_ff <= SQ1_W'(s1_ff.interval) * SQ1_W'(s1_ff.interval);
   end

   // ---------------------------------------------------------------- window
   // a flag resolving this cycle empties the window before the next update
   assign flag_now = test_result.push & test_result.rsp.block_key;
   assign fill_eff = flag_now ? '0 : fill_ff;
   assign sum_eff  = flag_now ? '0 : sum_ff;
   assign sq_eff   = flag_now ? '0 : sq_ff;
   assign full_eff = fill_eff == FULL_COUNT;
   assign shift_en = s2_ff.valid & s2_ff.upd;

   // interval chain: new entry at cell 0, oldest falls out of the last cell
   for (genvar g = 0; g < WINDOW; g++) begin : g_cell
      if (g == 0) begin : g_head
         kta_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_iv     (s2_ff.interval),
            .d_sq     (s2_sq_ff),
            .q_iv     (cell_iv[g]),
            .q_sq     (cell_sq[g])
         );
      end else begin : g_body
         kta_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_iv     (cell_iv[g-1]),
            .d_sq     (cell_sq[g-1]),
            .q_iv     (cell_iv[g]),
            .q_sq     (cell_sq[g])
         );
      end
   end

   always_comb begin
      fill_in = fill_eff;
      sum_in  = sum_eff;
      sq_in   = sq_eff;
      if (shift_en) begin
         if (full_eff) begin
            // replace the oldest interval
            sum_in = sum_eff - SUM_W'(cell_iv[WINDOW-1]) + SUM_W'(s2_ff.interval);
            sq_in  = sq_eff - SQ_W'(cell_sq[WINDOW-1]) + SQ_W'(s2_sq_ff);
         end else begin
            fill_in = fill_eff + CNT_W'(1);
            sum_in  = sum_eff + SUM_W'(s2_ff.interval);
            sq_in   = sq_eff + SQ_W'(s2_sq_ff);
         end
      end
   end

   always_comb begin
      s3_in = s2_ff;
      if (s2_ff.upd) begin
         s3_in.full = fill_in == FULL_COUNT;
      end else if (s2_ff.key) begin
         // first key-down after reset only records its time
         s3_in.full = 1'b0;
      end else begin
         s3_in.full = full_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         s3_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         s3_ff   <= s3_in;
      end
   end

   // ---------------------------------------------------------------- test
   kta_test #(
      .WINDOW (WINDOW)
   ) u_test (
      .clock      (clock),
      .reset      (reset),
      .s3         (s3_ff),
      .sum        (sum_ff),
      .sq         (sq_ff),
      .mean_limit (mean_limit_ff),
      .var_limit  (var_limit_ff),
      .result     (test_result)
   );

   // ---------------------------------------------------------------- output
   kta_out_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (test_result.push),
      .push_data (test_result.rsp),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (fifo_out)
   );

   assign rsp_tdata = fifo_out.interval_ms;
   assign rsp_tuser = {fifo_out.window_full, fifo_out.block_key};

endmodule

// ----- hdl/kta_cell.sv -----
// one cell of the interval chain: holds an interval and its square
`timescale 1ns / 1ps

module kta_cell (
   input  logic                      clock,
   input  logic                      shift_en,
   input  logic [kta_pkg::IV_W-1:0]  d_iv,
   input  logic [kta_pkg::SQ1_W-1:0] d_sq,
   output logic [kta_pkg::IV_W-1:0]  q_iv,
   output logic [kta_pkg::SQ1_W-1:0] q_sq
);
   import kta_pkg::*;

   logic [IV_W-1:0]  iv_ff;
   logic [SQ1_W-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         iv_ff <= d_iv;
         sq_ff <= d_sq;
      end
   end

   assign q_iv = iv_ff;
   assign q_sq = sq_ff;

endmodule

// ----- hdl/kta_test.sv -----
// flat-window test: registered products and mean compare, then spread compare
`timescale 1ns / 1ps

module kta_test #(
   parameter int WINDOW = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kta_pkg::stage_type                s3,
   input  logic [kta_pkg::IV_W+$clog2(WINDOW)-1:0]  sum,
   input  logic [kta_pkg::SQ1_W+$clog2(WINDOW)-1:0] sq,
   input  logic [kta_pkg::MEAN_W-1:0]        mean_limit,
   input  logic [kta_pkg::VLIM_W-1:0]        var_limit,
   output kta_pkg::test_result_type          result
);
   import kta_pkg::*;

   localparam int SUM_W = IV_W + $clog2(WINDOW);
   localparam int CMP_W = 2 * SUM_W;

   stage_type        info_ff;
   logic [CMP_W-1:0] prod_ff, prod_in;
   logic [CMP_W-1:0] nsq_ff, nsq_in;
   logic             mean_ok_ff, mean_ok_in;
   logic [SUM_W-1:0] mean_bound;
   logic [CMP_W-1:0] var_bound;
   logic [CMP_W-1:0] spread;
   logic             flat;

   assign mean_bound = SUM_W'(mean_limit) * SUM_W'(WINDOW);
   assign mean_ok_in = sum < mean_bound;
   assign prod_in    = CMP_W'(sum) * CMP_W'(sum);
   assign nsq_in     = CMP_W'(sq) * CMP_W'(WINDOW);

   always_ff @(posedge clock) begin
      if (reset) begin
         info_ff <= '0;
      end else begin
         info_ff <= s3;
      end
      prod_ff    <= prod_in;
      nsq_ff     <= nsq_in;
      mean_ok_ff <= mean_ok_in;
   end

   // window * sumsq never drops below sum^2, so no wrap here
   assign var_bound = CMP_W'(var_limit) * CMP_W'(WINDOW * WINDOW);
   assign spread    = nsq_ff - prod_ff;
   assign flat      = mean_ok_ff & (spread < var_bound);

   assign result.push            = info_ff.valid;
   assign result.rsp.block_key   = info_ff.valid & info_ff.upd & info_ff.full & flat;
   assign result.rsp.interval_ms = info_ff.interval;
   assign result.rsp.window_full = info_ff.full;

endmodule

// ----- hdl/kta_out_fifo.sv -----
// small result queue between the pipeline and the result channel
`timescale 1ns / 1ps

module kta_out_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  kta_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output kta_pkg::rsp_type out_data
);
   import kta_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop_ok    = pop & out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/kta_checker.sv -----
// port-level checker of the keystroke timing anomaly detector, with its bind
`timescale 1ns / 1ps

module kta_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [kta_pkg::IV_W-1:0]  rsp_tdata,
   input logic [1:0]                rsp_tuser
);
   import kta_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // after each accepted event req_tready goes low
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken in consecutive cycles");

   // a flagged key always comes from a full window
   a_block_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[1])
      else $error("block flag without a full window");

   // nothing queued right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind keystroke_timing_anomaly_detector kta_checker u_kta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/keystroke_timing_anomaly_detector_tb.sv -----
// testbench for the keystroke timing anomaly detector: directed and random event streams
`timescale 1ns / 1ps

// Drives key-down and other events into the detector and checks every result
// against a behavioral predictor of the interval window. The predictor keeps
// its own ring, running sums and register copies and works out the expected
// block/interval/window-full result for each accepted input transfer. A checker
// process compares each output transfer with the oldest pending expectation.
// Stimulus: a directed sequence at reset settings, register extremes, then
// phases of random settings with mostly flat typing bursts (to reach flags)
// mixed with noise events, wraps and saturated gaps. Both sides idle at random

module keystroke_timing_anomaly_detector_tb;

   import kta_pkg::*;

   localparam int          WIN          = 20;
   localparam realtime     HALF_PERIOD  = 6ns;
   localparam int          RESET_CYCLES = 8;
   localparam int          SETTLE       = 12;    // settling time before the final check
   localparam int          STALL_LIMIT  = 3000;  // cycles with no transfer at all
   localparam int          PHASES       = 12;
   localparam int          PHASE_EVENTS = 115;

   // indexes outside the register list, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TIME_W-1:0]     req_tdata;   // [31:0] time_ms
   logic                  req_tuser;   // [0] key_down
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [IV_W-1:0]       rsp_tdata;   // [15:0] interval_ms
   logic [1:0]            rsp_tuser;   // [0] block_key, [1] window_full
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   keystroke_timing_anomaly_detector #(
      .WINDOW(WIN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // predictor state: interval window and register copies
   logic [IV_W-1:0]   gap_ring [WIN];
   int                wr_slot;
   int                held;
   logic [20:0]       run_sum;
   logic [36:0]       run_sq;
   logic [TIME_W-1:0] prev_time;
   bit                have_prev;
   logic [MEAN_W-1:0] mean_lim;
   logic [VLIM_W-1:0] var_lim;

   rsp_type expected_verdicts[$];

   // stimulus knobs and bookkeeping
   bit                tx_idle;
   bit                rx_idle;
   int                rx_stall_left;
   logic [TIME_W-1:0] clock_ms;        // running timestamp of the typist
   int                quiet_cycles;
   int                n_fail;
   int                n_events;
   int                n_keys;
   int                n_flags;
   int                n_full;
   int                n_csr;

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_window();
      wr_slot = 0;
      held    = 0;
      run_sum = '0;
      run_sq  = '0;
   endfunction

   // expected result of one event, advances the predictor state
   function automatic rsp_type judge_keystroke(input bit key, input logic [TIME_W-1:0] now);
      rsp_type           verdict;
      logic [TIME_W-1:0] delta;
      logic [IV_W-1:0]   gap_ms;
      logic [IV_W-1:0]   oldest;
      logic [63:0]       spread;
      verdict = '0;
      // other events only report whether the window is full
      if (!key) begin
         verdict.window_full = (held == WIN);
         return verdict;
      end
      if (have_prev) begin
         delta  = now - prev_time;
         gap_ms = (delta > TIME_W'(IV_MAX)) ? IV_MAX : delta[IV_W-1:0];
         // full window: the oldest interval drops out of both sums
         if (held == WIN) begin
            oldest  = gap_ring[wr_slot];
            run_sum = run_sum - 21'(oldest);
            run_sq  = run_sq - 37'(64'(oldest) * 64'(oldest));
         end else begin
            held++;
         end
         gap_ring[wr_slot] = gap_ms;
         run_sum = run_sum + 21'(gap_ms);
         run_sq  = run_sq + 37'(64'(gap_ms) * 64'(gap_ms));
         wr_slot = (wr_slot + 1 == WIN) ? 0 : wr_slot + 1;
         verdict.interval_ms = gap_ms;
         if (held == WIN) begin
            verdict.window_full = 1'b1;
            // N*sumsq - sum^2 against variance_limit*N^2, sum against mean_limit*N
            spread = 64'(WIN) * 64'(run_sq) - 64'(run_sum) * 64'(run_sum);
            if (64'(run_sum) < 64'(mean_lim) * 64'(WIN) &&
                spread < 64'(var_lim) * 64'(WIN) * 64'(WIN)) begin
               verdict.block_key = 1'b1;
               clear_window();
            end
         end
      end
      prev_time = now;
      have_prev = 1'b1;
      return verdict;
   endfunction

   // one event transfer, the expectation is queued at the handshake
   task automatic send_event(input bit key, input logic [TIME_W-1:0] stamp);
      int      idle_len;
      rsp_type verdict;
      idle_len = tx_idle ? pick_idle_len() : 0;
      @(negedge clock);
      if (idle_len > 0) begin
         req_tvalid = 1'b0;
         repeat (idle_len) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = key;
      req_tdata  = stamp;
      do @(posedge clock); while (!req_tready);
      verdict = judge_keystroke(key, stamp);
      expected_verdicts = {expected_verdicts, verdict};
      n_events++;
      if (key) n_keys++;
      if (verdict.block_key) n_flags++;
      if (verdict.window_full) n_full++;
   endtask

   // stop sending and wait until every expected result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      // upper bits beyond the register width are dropped, unknown indexes ignored
      if (idx == CSR_MEAN_LIMIT) mean_lim = value[MEAN_W-1:0];
      else if (idx == CSR_VAR_LIMIT) var_lim = value[VLIM_W-1:0];
      n_csr++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // steady typing: key-downs at base + jitter, other events sprinkled in
   task automatic type_burst(input int keys, input int base, input int jitter);
      for (int k = 0; k < keys; k++) begin
         if ($urandom_range(0, 99) < 8) send_event(1'b0, $urandom());
         // a rare pause mid-burst until the output side has caught up
         if ($urandom_range(0, 199) == 0) wait_drained();
         clock_ms = clock_ms + TIME_W'(base + $urandom_range(0, jitter));
         send_event(1'b1, clock_ms);
      end
   endtask

   // irregular events: random stamps, long gaps, saturated intervals
   task automatic type_noise(input int count);
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 3))
            0: send_event(1'b0, $urandom());
            1: begin
               clock_ms = $urandom();
               send_event(1'b1, clock_ms);
            end
            2: begin
               clock_ms = clock_ms + TIME_W'($urandom_range(0, 140000));
               send_event(1'b1, clock_ms);
            end
            default: begin
               clock_ms = clock_ms + TIME_W'($urandom_range(0, 200));
               send_event(1'b1, clock_ms);
            end
         endcase
      end
   endtask

   // reset settings: first key-down, a flat window that flags across the time wrap,
   // the emptied window afterwards, saturated and near-saturated intervals
   task automatic test_directed_sequence();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      send_event(1'b0, '1);
      clock_ms = 32'hFFFF_FFD0;
      send_event(1'b1, clock_ms);
      for (int k = 0; k < WIN; k++) begin
         clock_ms = clock_ms + 32'd5;
         send_event(1'b1, clock_ms);
      end
      send_event(1'b0, '0);
      clock_ms = clock_ms + 32'h0001_0000;
      send_event(1'b1, clock_ms);
      clock_ms = clock_ms + 32'h0000_FFFF;
      send_event(1'b1, clock_ms);
      clock_ms = clock_ms + 32'hFFFF_FFFF;
      send_event(1'b1, clock_ms);
      wait_drained();
   endtask

   // both registers at their extremes, masking of wide writes, unknown indexes
   task automatic test_register_extremes();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      write_register(CSR_MEAN_LIMIT, '1);
      write_register(CSR_VAR_LIMIT, '1);
      write_register(CSR_UNMAPPED_LO, '0);
      write_register(CSR_UNMAPPED_HI, '0);
      type_burst(22, 1000, 40);
      wait_drained();
      // zero limits: nothing can flag
      write_register(CSR_MEAN_LIMIT, '0);
      write_register(CSR_VAR_LIMIT, '0);
      type_burst(22, 0, 0);
      wait_drained();
      // a zero-spread window still needs a variance limit above zero
      write_register(CSR_MEAN_LIMIT, CSR_DATA_W'(1));
      type_burst(21, 0, 0);
      wait_drained();
      write_register(CSR_VAR_LIMIT, CSR_DATA_W'(1));
      type_burst(21, 0, 0);
      wait_drained();
   endtask

   // random settings per phase, mostly flat bursts that can reach a flag
   task automatic test_random_phases();
      int first;
      int base;
      int jitter;
      int r;
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case ($urandom_range(0, 3))
            0: write_register(CSR_MEAN_LIMIT, '0);
            1: write_register(CSR_MEAN_LIMIT, '1);
            2: write_register(CSR_MEAN_LIMIT, CSR_DATA_W'($urandom_range(1, 60)));
            default: write_register(CSR_MEAN_LIMIT, CSR_DATA_W'($urandom()));
         endcase
         case ($urandom_range(0, 3))
            0: write_register(CSR_VAR_LIMIT, '0);
            1: write_register(CSR_VAR_LIMIT, '1);
            2: write_register(CSR_VAR_LIMIT, CSR_DATA_W'($urandom_range(0, 30)));
            default: write_register(CSR_VAR_LIMIT, CSR_DATA_W'($urandom()));
         endcase
         // some phases run without any idling on one side or both
         tx_idle = (p % 3 != 0);
         rx_idle = (p % 4 != 1);
         first = n_events;
         while (n_events - first < PHASE_EVENTS) begin
            if ($urandom_range(0, 99) < 75) begin
               if (mean_lim != 0 && $urandom_range(0, 99) < 80)
                  base = $urandom_range(0, int'(mean_lim) - 1);
               else
                  base = $urandom_range(0, 2000);
               r = $urandom_range(0, 99);
               jitter = (r < 60) ? 1 : (r < 90) ? 4 : 30;
               type_burst($urandom_range(WIN, 45), base, jitter);
            end else begin
               type_noise($urandom_range(1, 8));
            end
         end
      end
   endtask

   // output side: random stalls when enabled
   initial begin
      rsp_tready    = 1'b1;
      rx_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rx_idle && rx_stall_left == 0 && $urandom_range(0, 99) < 15)
            rx_stall_left = pick_idle_len();
         if (rx_stall_left > 0) begin
            rsp_tready = 1'b0;
            rx_stall_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $error("result transfer with no event outstanding: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            n_fail++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tuser[0] !== want.block_key) begin
               $error("block_key mismatch: expected %0d, actual %0d",
                      want.block_key, rsp_tuser[0]);
               n_fail++;
            end
            if (rsp_tdata !== want.interval_ms) begin
               $error("interval_ms mismatch: expected %0d, actual %0d",
                      want.interval_ms, rsp_tdata);
               n_fail++;
            end
            if (rsp_tuser[1] !== want.window_full) begin
               $error("window_full mismatch: expected %0d, actual %0d",
                      want.window_full, rsp_tuser[1]);
               n_fail++;
            end
         end
      end
   end

   // watchdog: cycles in which no channel moves a transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid === 1'b1 && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $error("no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, expected_verdicts.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      tx_idle      = 1'b0;
      rx_idle      = 1'b0;
      quiet_cycles = 0;
      n_fail       = 0;
      n_events     = 0;
      n_keys       = 0;
      n_flags      = 0;
      n_full       = 0;
      n_csr        = 0;
      clock_ms     = '0;
      // predictor at its reset state
      foreach (gap_ring[i]) gap_ring[i] = '0;
      clear_window();
      prev_time = '0;
      have_prev = 1'b0;
      mean_lim  = MEAN_RESET;
      var_lim   = VLIM_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_sequence();
      test_register_extremes();
      test_random_phases();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d results never arrived", expected_verdicts.size());
         n_fail++;
      end

      $display("summary: %0d events (%0d key-downs), %0d register writes",
               n_events, n_keys, n_csr);
      $display("summary: %0d results with a full window, %0d keys flagged as injected",
               n_full, n_flags);
      if (n_fail == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
